/* rtl/mbp_pkg.sv */
// shared types, constants and helpers for the midi byte parser with link timeout
`default_nettype none
package mbp_pkg;

   localparam int unsigned TimeoutWidth = 16;
   localparam int unsigned IdleWidth    = 17;
   localparam int unsigned CsrAddrWidth = 3;
   localparam int unsigned CsrDataWidth = 32;

   localparam logic [TimeoutWidth-1:0] IdleTimeoutReset = 16'd1500;
   localparam logic [IdleWidth-1:0]    IdleTicksMax     = 17'h1FFFF;

   localparam logic [7:0] RealTimeFirst = 8'hF8;
   localparam logic [7:0] SystemFirst   = 8'hF0;
   localparam logic [7:0] SongPosition  = 8'hF2;
   localparam logic [7:0] TimeCode      = 8'hF1;
   localparam logic [7:0] SongSelect    = 8'hF3;

   localparam logic [3:0] NibNoteOff    = 4'h8;
   localparam logic [3:0] NibNoteOn     = 4'h9;
   localparam logic [3:0] NibPolyPress  = 4'hA;
   localparam logic [3:0] NibControl    = 4'hB;
   localparam logic [3:0] NibProgram    = 4'hC;
   localparam logic [3:0] NibChanPress  = 4'hD;
   localparam logic [3:0] NibPitchBend  = 4'hE;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic {
      REG_IDLE_TIMEOUT = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic [7:0]           running_status;
      logic [6:0]           held_data;
      logic                 data_index;
      logic [1:0]           bytes_needed;
      logic                 connected;
      logic [IdleWidth-1:0] idle_ticks;
   } parser_state_type;

   typedef struct packed {
      logic       message_valid;
      logic [7:0] message_status;
      logic [6:0] first_data;
      logic [6:0] second_data;
      logic       link_up;
      logic       link_changed;
   } parser_result_type;

   function automatic logic [1:0] data_count_for(input logic [7:0] st);
      logic [1:0] n;
      n = 2'd0;
      case (st[7:4])
         NibNoteOff, NibNoteOn, NibPolyPress, NibControl, NibPitchBend: n = 2'd2;
         NibProgram, NibChanPress: n = 2'd1;
         default: begin
            if (st == SongPosition) begin
               n = 2'd2;
            end else if (st == TimeCode || st == SongSelect) begin
               n = 2'd1;
            end
         end
      endcase
      return n;
   endfunction

endpackage
`default_nettype wire

/* rtl/midi_byte_parser_with_link_timeout_core.sv */
// top level: input register, parser step logic, result register and csr port
// an accepted transaction waits in the input register, passes the step logic and lands in the result register
// throughput: one transaction per cycle while rsp_stall does not hold the result register, set by the
// combinational step logic between the input register and the result register
// reset: synchronous, clears state, valids and restores idle_timeout to 1500
`default_nettype none
module midi_byte_parser_with_link_timeout_core
   import mbp_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_operation,
   input  logic [7:0]                req_rx_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_message_valid,
   output logic [7:0]                rsp_message_status,
   output logic [6:0]                rsp_first_data,
   output logic [6:0]                rsp_second_data,
   output logic                      rsp_link_up,
   output logic                      rsp_link_changed,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CsrAddrWidth-1:0]   csr_paddr,
   input  logic [CsrDataWidth-1:0]   csr_pwdata,
   output logic [CsrDataWidth-1:0]   csr_prdata,
   output logic                      csr_pready
);

   logic                    in_valid_ff, in_valid_in;
   op_type                  in_op_ff;
   logic [7:0]              in_byte_ff;
   logic                    out_valid_ff, out_valid_in;
   parser_result_type       out_ff;
   parser_state_type        state_ff, state_in;
   parser_result_type       step_result;
   logic [TimeoutWidth-1:0] timeout_ff;
   logic                    accept, advance, reg_sel, csr_write;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   assign reg_sel   = (reg_index_type'(csr_paddr[CsrAddrWidth-1]) == REG_IDLE_TIMEOUT);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? CsrDataWidth'(timeout_ff) : '0;

   mbp_step u_step (
      .state        (state_ff),
      .operation    (in_op_ff),
      .rx_byte      (in_byte_ff),
      .idle_timeout (timeout_ff),
      .state_next   (state_in),
      .result       (step_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
         timeout_ff   <= IdleTimeoutReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_write && reg_sel) begin
            timeout_ff <= csr_pwdata[TimeoutWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= op_type'(req_operation);
         in_byte_ff <= req_rx_byte;
      end
      if (advance) begin
         out_ff <= step_result;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_message_valid  = out_ff.message_valid;
   assign rsp_message_status = out_ff.message_status;
   assign rsp_first_data     = out_ff.first_data;
   assign rsp_second_data    = out_ff.second_data;
   assign rsp_link_up        = out_ff.link_up;
   assign rsp_link_changed   = out_ff.link_changed;

endmodule
`default_nettype wire

/* rtl/mbp_step.sv */
// next-state and result logic for one byte or tick transaction
`default_nettype none
module mbp_step
   import mbp_pkg::*;
(
   input  parser_state_type          state,
   input  op_type                    operation,
   input  logic [7:0]                rx_byte,
   input  logic [TimeoutWidth-1:0]   idle_timeout,
   output parser_state_type          state_next,
   output parser_result_type         result
);

   logic [IdleWidth-1:0] ticks_inc;

   always_comb begin
      ticks_inc = (state.idle_ticks < IdleTicksMax) ?
                  state.idle_ticks + IdleWidth'(1) : state.idle_ticks;
   end

   always_comb begin
      state_next = state;
      result     = '0;
      if (operation == OP_BYTE) begin
         if (!state.connected) begin
            state_next.connected = 1'b1;
            result.link_changed  = 1'b1;
         end
         state_next.idle_ticks = '0;
         if (rx_byte >= RealTimeFirst) begin
            // real-time byte, parser untouched
         end else if (rx_byte[7]) begin
            state_next.data_index = 1'b0;
            if (rx_byte >= SystemFirst) begin
               state_next.running_status = '0;
               state_next.bytes_needed   = '0;
            end else begin
               state_next.running_status = rx_byte;
               state_next.bytes_needed   = data_count_for(rx_byte);
            end
         end else if (state.running_status != '0 && state.bytes_needed != '0) begin
            if (!state.data_index) begin
               if (state.bytes_needed <= 2'd1) begin
                  result.message_valid  = 1'b1;
                  result.message_status = state.running_status;
                  result.first_data     = rx_byte[6:0];
               end else begin
                  state_next.held_data  = rx_byte[6:0];
                  state_next.data_index = 1'b1;
               end
            end else begin
               result.message_valid  = 1'b1;
               result.message_status = state.running_status;
               result.first_data     = state.held_data;
               result.second_data    = (state.bytes_needed >= 2'd2) ? rx_byte[6:0] : '0;
               state_next.data_index = 1'b0;
            end
         end
      end else begin
         state_next.idle_ticks = ticks_inc;
         if (state.connected && ticks_inc > {1'b0, idle_timeout}) begin
            state_next.connected      = 1'b0;
            state_next.running_status = '0;
            result.link_changed       = 1'b1;
         end
      end
      result.link_up = state_next.connected;
   end

endmodule
`default_nettype wire
